// File: hw/rtl/fnpd_pkg.sv
package fnpd_pkg;

    localparam int FREQ_W = 33;
    localparam int REF_W  = 30;

    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic [REF_W-1:0]  t_ref;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd2;

    // prescaler modes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // VCO bands
    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    // register indexes
    localparam logic [2:0] REG_REF_CLK   = 3'd0;
    localparam logic [2:0] REG_LOW_MIN   = 3'd1;
    localparam logic [2:0] REG_LOW_MAX   = 3'd2;
    localparam logic [2:0] REG_MID_MIN   = 3'd3;
    localparam logic [2:0] REG_MID_MAX   = 3'd4;
    localparam logic [2:0] REG_HIGH_MIN  = 3'd5;
    localparam logic [2:0] REG_HIGH_MAX  = 3'd6;
    localparam logic [2:0] REG_THRESHOLD = 3'd7;

    // register reset values
    localparam t_ref  RST_REF_CLK   = 30'd30720000;
    localparam t_freq RST_LOW_MIN   = 33'd3800000000;
    localparam t_freq RST_LOW_MAX   = 33'd5222000000;
    localparam t_freq RST_MID_MIN   = 33'd4961000000;
    localparam t_freq RST_MID_MAX   = 33'd6754000000;
    localparam t_freq RST_HIGH_MIN  = 33'd6306000000;
    localparam t_freq RST_HIGH_MAX  = 33'd7714000000;
    localparam t_freq RST_THRESHOLD = 33'd5500000000;

    typedef struct packed {
        t_ref  ref_clk;
        t_freq low_min;
        t_freq low_max;
        t_freq mid_min;
        t_freq mid_max;
        t_freq high_min;
        t_freq high_max;
        t_freq threshold;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [1:0] band;
        logic [2:0] code;
        logic       presc;
        t_freq      fvco;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

// File: hw/rtl/fractional_n_pll_divider_calc_core.sv
// Fractional-N PLL divider calculator. A request (frequency in Hz, prescaler
// mode) is clamped, matched to a VCO band and output divider, and turned into
// integer and fractional feedback divider words plus the VCO and achieved
// frequencies, all in integer Hz. A two-stage front takes a request every
// cycle, stalling while its last stage holds a word and the four-entry queue
// is full; the back computes one result at a time. Its cost is set by the
// long division of the VCO frequency by the reference, done two quotient bits
// per cycle. Results come out in request order. The user must write registers
// only while the block is idle; the block itself does not enforce this.
module fractional_n_pll_divider_calc_core #(
    parameter int FRAC_BITS = 20,
    parameter int INT_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [32:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fnpd_pkg::t_freq        i_desired_freq,
    input  logic [1:0]           i_div2_mode,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [1:0]           o_vco_select,
    output logic [2:0]           o_divider_index,
    output logic                 o_prescaler_on,
    output logic [INT_BITS-1:0]  o_int_divider,
    output logic [FRAC_BITS-1:0] o_frac_divider,
    output fnpd_pkg::t_freq        o_vco_freq,
    output fnpd_pkg::t_freq        o_real_freq
);
    import fnpd_pkg::*;

    t_cfg r_cfg;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_clk   <= RST_REF_CLK;
            r_cfg.low_min   <= RST_LOW_MIN;
            r_cfg.low_max   <= RST_LOW_MAX;
            r_cfg.mid_min   <= RST_MID_MIN;
            r_cfg.mid_max   <= RST_MID_MAX;
            r_cfg.high_min  <= RST_HIGH_MIN;
            r_cfg.high_max  <= RST_HIGH_MAX;
            r_cfg.threshold <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REF_CLK:   r_cfg.ref_clk   <= i_cfg_data[REF_W-1:0];
                REG_LOW_MIN:   r_cfg.low_min   <= i_cfg_data;
                REG_LOW_MAX:   r_cfg.low_max   <= i_cfg_data;
                REG_MID_MIN:   r_cfg.mid_min   <= i_cfg_data;
                REG_MID_MAX:   r_cfg.mid_max   <= i_cfg_data;
                REG_HIGH_MIN:  r_cfg.high_min  <= i_cfg_data;
                REG_HIGH_MAX:  r_cfg.high_max  <= i_cfg_data;
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fnpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_desired_freq (i_desired_freq),
        .i_div2_mode    (i_div2_mode),
        .i_cfg          (r_cfg),
        .i_full         (full),
        .o_push         (push),
        .o_job          (job_in)
    );

    fnpd_queue #(.DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    fnpd_back #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_job           (job_out),
        .o_pop           (pop),
        .i_ref_clk       (r_cfg.ref_clk),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_vco_select    (o_vco_select),
        .o_divider_index (o_divider_index),
        .o_prescaler_on  (o_prescaler_on),
        .o_int_divider   (o_int_divider),
        .o_frac_divider  (o_frac_divider),
        .o_vco_freq      (o_vco_freq),
        .o_real_freq     (o_real_freq)
    );

endmodule

// File: hw/rtl/fnpd_front.sv
module fnpd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fnpd_pkg::t_freq i_desired_freq,
    input  logic [1:0]    i_div2_mode,
    input  fnpd_pkg::t_cfg  i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output fnpd_pkg::t_job  o_job
);
    import fnpd_pkg::*;

    logic       adv;
    t_freq      clamp_f;
    logic [1:0] clamp_st;
    logic [33:0] lo_round;

    logic       r_s1_v;
    t_freq      r_s1_f;
    logic [1:0] r_s1_status;
    logic [1:0] r_s1_mode;

    logic       r_s2_v;
    t_job       r_s2;
    t_job       n_s2;

    t_freq      lo [3];
    t_freq      hi [3];
    logic [39:0] v;

    // front moves as one unit; it holds only when its last word cannot enter the queue
    assign adv        = !(r_s2_v && i_full);
    assign o_in_stall = !adv;
    assign o_push     = r_s2_v && adv;
    assign o_job      = r_s2;

    // clamp to the deliverable range, maximum checked first
    always_comb begin
        lo_round = 34'(i_cfg.low_min) + 34'd127;
        clamp_f  = i_desired_freq;
        clamp_st = STATUS_OK;
        if ({i_desired_freq, 1'b0} > {1'b0, i_cfg.high_max}) begin
            clamp_f  = i_cfg.high_max >> 1;
            clamp_st = STATUS_CLAMPED;
        end else if ({i_desired_freq, 7'b0} < {7'b0, i_cfg.low_min}) begin
            clamp_f  = FREQ_W'(lo_round >> 7);
            clamp_st = STATUS_CLAMPED;
        end
    end

    // band and divider search: high band first, largest divider first
    always_comb begin
        lo[0] = i_cfg.low_min;  hi[0] = i_cfg.low_max;
        lo[1] = i_cfg.mid_min;  hi[1] = i_cfg.mid_max;
        lo[2] = i_cfg.high_min; hi[2] = i_cfg.high_max;
        n_s2  = '0;
        v     = '0;
        for (int b = 2; b >= 0; b--) begin
            for (int k = 6; k >= 0; k--) begin
                v = 40'(r_s1_f) << (k + 1);
                if (!n_s2.found && v >= 40'(lo[b]) && v <= 40'(hi[b])) begin
                    n_s2.found = 1'b1;
                    n_s2.band  = 2'(b);
                    n_s2.code  = 3'(k);
                    n_s2.fvco  = v[FREQ_W-1:0];
                end
            end
        end
        n_s2.status = n_s2.found ? r_s1_status : STATUS_NO_FIT;
        if (r_s1_mode == MODE_ON) begin
            n_s2.presc = 1'b1;
        end else if (r_s1_mode == MODE_OFF) begin
            n_s2.presc = 1'b0;
        end else begin
            n_s2.presc = n_s2.fvco > i_cfg.threshold;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_f      <= clamp_f;
            r_s1_status <= clamp_st;
            r_s1_mode   <= i_div2_mode;
            r_s2        <= n_s2;
        end
    end

endmodule

// File: hw/rtl/fnpd_queue.sv
module fnpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fnpd_pkg::t_job  i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output fnpd_pkg::t_job  o_job
);
    import fnpd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: hw/rtl/fnpd_back.sv
module fnpd_back #(
    parameter int FRAC_BITS = 20,
    parameter int INT_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  fnpd_pkg::t_job         i_job,
    output logic                 o_pop,
    input  fnpd_pkg::t_ref         i_ref_clk,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [1:0]           o_vco_select,
    output logic [2:0]           o_divider_index,
    output logic                 o_prescaler_on,
    output logic [INT_BITS-1:0]  o_int_divider,
    output logic [FRAC_BITS-1:0] o_frac_divider,
    output fnpd_pkg::t_freq        o_vco_freq,
    output fnpd_pkg::t_freq        o_real_freq
);
    import fnpd_pkg::*;

    localparam int DEN_W = REF_W + 1;
    localparam int DVD_W = FREQ_W + FRAC_BITS;
    localparam int DVD_E = DVD_W + (DVD_W % 2);
    localparam int ITER  = DVD_E / 2;
    localparam int CNT_W = $clog2(ITER);
    localparam int QI_W  = DVD_E - FRAC_BITS;
    localparam int A_W   = INT_BITS + 1 + REF_W;
    localparam int B_W   = FRAC_BITS + REF_W;
    localparam int S_W   = A_W + 2;
    localparam logic [INT_BITS-1:0] IMAX = '1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    logic [1:0]       r_st;
    t_job             r_job;
    t_ref             r_ref;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DVD_E-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [INT_BITS-1:0]  r_nint;
    logic [FRAC_BITS-1:0] r_frac;
    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_bb;

    logic [DEN_W-1:0] n_rem;
    logic [DVD_E-1:0] n_quo;
    logic [DEN_W:0]   tmp;
    logic             ge;
    t_ref             ref_eff;
    logic [QI_W-1:0]  q_int;
    logic [QI_W-1:0]  q_m4;
    logic [INT_BITS-1:0] nint;
    logic [S_W-1:0]   a_s;
    logic [B_W:0]     bb_s;
    logic [S_W-1:0]   sum;
    logic [S_W-1:0]   real_w;
    t_freq            real_sat;
    logic             out_free;

    assign ref_eff  = (i_ref_clk == '0) ? REF_W'(1) : i_ref_clk;
    assign o_pop    = (r_st == ST_IDLE) && !i_empty;
    assign out_free = !o_out_valid || !i_out_stall;

    // two restoring division steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        tmp   = '0;
        ge    = 1'b0;
        for (int s = 0; s < 2; s++) begin
            tmp = {n_rem, n_quo[DVD_E-1]};
            ge  = tmp >= {1'b0, r_den};
            if (ge) begin
                tmp = tmp - {1'b0, r_den};
            end
            n_rem = tmp[DEN_W-1:0];
            n_quo = {n_quo[DVD_E-2:0], ge};
        end
    end

    // integer part minus four, saturated both ways
    always_comb begin
        q_int = r_quo[DVD_E-1:FRAC_BITS];
        q_m4  = q_int - QI_W'(4);
        if (q_int < QI_W'(4)) begin
            nint = '0;
        end else if (q_m4 > QI_W'(IMAX)) begin
            nint = IMAX;
        end else begin
            nint = q_m4[INT_BITS-1:0];
        end
    end

    // achieved frequency from the products
    always_comb begin
        a_s    = S_W'(r_a) << r_job.presc;
        bb_s   = (B_W+1)'(r_bb) << r_job.presc;
        sum    = a_s + S_W'(bb_s >> FRAC_BITS);
        real_w = sum >> (r_job.code + 3'd1);
        real_sat = (real_w > S_W'({FREQ_W{1'b1}})) ? '1 : real_w[FREQ_W-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_st <= i_job.found ? ST_DIV : ST_SUM;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == CNT_W'(ITER - 1)) begin
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: r_st <= ST_SUM;
                ST_SUM: begin
                    if (out_free) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_ref <= ref_eff;
                r_den <= DEN_W'(ref_eff) << i_job.presc;
                r_rem <= '0;
                r_quo <= DVD_E'({i_job.fvco, {FRAC_BITS{1'b0}}});
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_MUL: begin
                r_nint <= nint;
                r_frac <= r_quo[FRAC_BITS-1:0];
                r_a    <= A_W'(A_W'(nint) + A_W'(4)) * A_W'(r_ref);
                r_bb   <= B_W'(r_quo[FRAC_BITS-1:0]) * B_W'(r_ref);
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_st == ST_SUM && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_SUM && out_free) begin
            o_status <= r_job.status;
            if (r_job.found) begin
                o_vco_select    <= r_job.band;
                o_divider_index <= r_job.code;
                o_prescaler_on  <= r_job.presc;
                o_int_divider   <= r_nint;
                o_frac_divider  <= r_frac;
                o_vco_freq      <= r_job.fvco;
                o_real_freq     <= real_sat;
            end else begin
                o_vco_select    <= '0;
                o_divider_index <= '0;
                o_prescaler_on  <= 1'b0;
                o_int_divider   <= '0;
                o_frac_divider  <= '0;
                o_vco_freq      <= '0;
                o_real_freq     <= '0;
            end
        end
    end

endmodule

// File: tb/sv/fnpd_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels, predicts each result and compares.
module fnpd_checker #(
    parameter int FRAC_BITS = 20,
    parameter int INT_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [32:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  fnpd_pkg::t_freq      i_desired_freq,
    input  logic [1:0]           i_div2_mode,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           i_status,
    input  logic [1:0]           i_vco_select,
    input  logic [2:0]           i_divider_index,
    input  logic                 i_prescaler_on,
    input  logic [INT_BITS-1:0]  i_int_divider,
    input  logic [FRAC_BITS-1:0] i_frac_divider,
    input  fnpd_pkg::t_freq      i_vco_freq,
    input  fnpd_pkg::t_freq      i_real_freq,
    output int                   o_fail_count,
    output int                   o_pending
);
    import fnpd_pkg::*;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           band;
        logic [2:0]           code;
        logic                 presc;
        logic [INT_BITS-1:0]  nint;
        logic [FRAC_BITS-1:0] frac;
        t_freq                fvco;
        t_freq                real_f;
    } t_setting;

    t_cfg     cfg;
    t_setting settings_due[$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending    = settings_due.size();

    // predict the divider setting for one request
    function automatic t_setting calc_setting(t_freq want, logic [1:0] mode);
        t_setting   s;
        logic [63:0] f, v, lo [3], hi [3], fvco, refc, den, q, rem, nint, frac, a, bb, r;
        logic [63:0] imax;
        logic       found, p;
        int         band, code;
        s = '0;
        f = want;
        found = 1'b0;
        band = 0;
        code = 0;
        fvco = 0;
        imax = (64'd1 << INT_BITS) - 1;
        if (2 * f > cfg.high_max) begin
            f = cfg.high_max >> 1;
            s.status = STATUS_CLAMPED;
        end else if (128 * f < cfg.low_min) begin
            f = (64'(cfg.low_min) + 127) >> 7;
            s.status = STATUS_CLAMPED;
        end
        lo[0] = cfg.low_min;  hi[0] = cfg.low_max;
        lo[1] = cfg.mid_min;  hi[1] = cfg.mid_max;
        lo[2] = cfg.high_min; hi[2] = cfg.high_max;
        for (int b = 2; b >= 0; b--) begin
            for (int k = 6; k >= 0; k--) begin
                v = f << (k + 1);
                if (!found && v >= lo[b] && v <= hi[b]) begin
                    found = 1'b1;
                    band = b;
                    code = k;
                    fvco = v;
                end
            end
        end
        if (!found) begin
            s = '0;
            s.status = STATUS_NO_FIT;
            return s;
        end
        p = fvco > cfg.threshold;
        if (mode == MODE_ON) p = 1'b1;
        else if (mode == MODE_OFF) p = 1'b0;
        refc = (cfg.ref_clk == 0) ? 64'd1 : 64'(cfg.ref_clk);
        den  = refc << p;
        q    = fvco / den;
        rem  = fvco % den;
        nint = (q < 4) ? 64'd0 : q - 4;
        if (nint > imax) nint = imax;
        frac = ((rem << FRAC_BITS) / den) & ((64'd1 << FRAC_BITS) - 1);
        a    = ((nint + 4) * refc) << p;
        bb   = (frac * refc) << p;
        r    = (a + (bb >> FRAC_BITS)) >> (code + 1);
        if (r > 64'h1_FFFF_FFFF) r = 64'h1_FFFF_FFFF;
        s.band   = band[1:0];
        s.code   = code[2:0];
        s.presc  = p;
        s.nint   = nint[INT_BITS-1:0];
        s.frac   = frac[FRAC_BITS-1:0];
        s.fvco   = fvco[32:0];
        s.real_f = r[32:0];
        return s;
    endfunction

    // register shadow, request capture, result compare
    always @(posedge i_clk) begin
        t_setting e;
        if (!i_rst_n) begin
            cfg <= '{RST_REF_CLK, RST_LOW_MIN, RST_LOW_MAX, RST_MID_MIN, RST_MID_MAX,
                     RST_HIGH_MIN, RST_HIGH_MAX, RST_THRESHOLD};
            settings_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_REF_CLK:   cfg.ref_clk   <= i_cfg_data[29:0];
                    REG_LOW_MIN:   cfg.low_min   <= i_cfg_data;
                    REG_LOW_MAX:   cfg.low_max   <= i_cfg_data;
                    REG_MID_MIN:   cfg.mid_min   <= i_cfg_data;
                    REG_MID_MAX:   cfg.mid_max   <= i_cfg_data;
                    REG_HIGH_MIN:  cfg.high_min  <= i_cfg_data;
                    REG_HIGH_MAX:  cfg.high_max  <= i_cfg_data;
                    REG_THRESHOLD: cfg.threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                settings_due.insert(settings_due.size(),
                                    calc_setting(i_desired_freq, i_div2_mode));
            if (i_out_valid && !i_out_stall) begin
                if (settings_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fails = fails + 1;
                end else begin
                    e = settings_due.pop_front();
                    if (e.status !== i_status) begin
                        $error("status exp %0d got %0d", e.status, i_status);
                        fails = fails + 1;
                    end
                    if (e.band !== i_vco_select) begin
                        $error("vco_select exp %0d got %0d", e.band, i_vco_select);
                        fails = fails + 1;
                    end
                    if (e.code !== i_divider_index) begin
                        $error("divider_index exp %0d got %0d", e.code, i_divider_index);
                        fails = fails + 1;
                    end
                    if (e.presc !== i_prescaler_on) begin
                        $error("prescaler_on exp %0d got %0d", e.presc, i_prescaler_on);
                        fails = fails + 1;
                    end
                    if (e.nint !== i_int_divider) begin
                        $error("int_divider exp %0d got %0d", e.nint, i_int_divider);
                        fails = fails + 1;
                    end
                    if (e.frac !== i_frac_divider) begin
                        $error("frac_divider exp %0d got %0d", e.frac, i_frac_divider);
                        fails = fails + 1;
                    end
                    if (e.fvco !== i_vco_freq) begin
                        $error("vco_freq exp %0d got %0d", e.fvco, i_vco_freq);
                        fails = fails + 1;
                    end
                    if (e.real_f !== i_real_freq) begin
                        $error("real_freq exp %0d got %0d", e.real_f, i_real_freq);
                        fails = fails + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/fractional_n_pll_divider_calc_core_tb.sv
`timescale 1ns / 1ps

module fractional_n_pll_divider_calc_core_tb;
    import fnpd_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = REG_REF_CLK;
    logic [32:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_freq       desired_freq = '0;
    logic [1:0]  div2_mode = MODE_AUTO;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status, vco_select;
    logic [2:0]  divider_index;
    logic        prescaler_on;
    logic [9:0]  int_divider;
    logic [19:0] frac_divider;
    t_freq       vco_freq, real_freq;
    int          fail_count, pending;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    int          hold_left = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fractional_n_pll_divider_calc_core u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_desired_freq(desired_freq), .i_div2_mode(div2_mode),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_status(status),
        .o_vco_select(vco_select), .o_divider_index(divider_index),
        .o_prescaler_on(prescaler_on), .o_int_divider(int_divider),
        .o_frac_divider(frac_divider), .o_vco_freq(vco_freq), .o_real_freq(real_freq)
    );

    fnpd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_desired_freq(desired_freq), .i_div2_mode(div2_mode),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_vco_select(vco_select), .i_divider_index(divider_index),
        .i_prescaler_on(prescaler_on), .i_int_divider(int_divider),
        .i_frac_divider(frac_divider), .i_vco_freq(vco_freq), .i_real_freq(real_freq),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (hold_go) begin
            hold_left <= 200;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    // watchdog on accepted words
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [32:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every result, then let the back end drain
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // valid stays up after acceptance; the caller drops it at the end of a burst
    task automatic send_request(input t_freq f, input logic [1:0] m);
        if (!calm) begin
            while ($urandom_range(99) < 10) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        desired_freq <= f;
        div2_mode    <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // random frequency: mostly in band, some anywhere
    function automatic t_freq pick_freq();
        logic [63:0] r;
        case ($urandom_range(9))
            0: r = {$urandom, $urandom};
            1: r = $urandom_range(100);
            2: r = 33'h1_FFFF_FFFF - $urandom_range(3);
            default: r = $urandom_range(7800000, 30000000) * 64'($urandom_range(1, 64))
                         + $urandom_range(1000000);
        endcase
        return r[32:0];
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
            send_request(pick_freq(), 2'($urandom_range(3)));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        t_freq edge_freqs [10];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, clamps, modes, band edges
        edge_freqs = '{33'd0, 33'h1_FFFF_FFFF, 33'd29687500, 33'd29687499,
                       33'd3857000000, 33'd3857000001, 33'd49265625, 33'd40797000,
                       33'd100000000, 33'd1};
        foreach (edge_freqs[i])
            for (int m = 0; m < 4; m++)
                if (i < 5 || m == 0) send_request(edge_freqs[i], 2'(m));
        random_phase(300);

        // long hold-off so the queue fills and stalls requests
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        random_phase(20);
        drain();

        // tiny reference: integer divider saturates high; gap in bands
        write_reg(REG_REF_CLK, 33'd0);
        write_reg(REG_MID_MIN, 33'd8000000000);
        write_reg(REG_THRESHOLD, 33'd0);
        random_phase(150);
        drain();

        // huge reference: quotient below four; everything at the extremes
        write_reg(REG_REF_CLK, 33'd1000000000);
        write_reg(REG_LOW_MIN, 33'd0);
        write_reg(REG_LOW_MAX, 33'h1_FFFF_FFFF);
        write_reg(REG_HIGH_MIN, 33'h1_FFFF_FFFF);
        write_reg(REG_HIGH_MAX, 33'h1_FFFF_FFFF);
        write_reg(REG_THRESHOLD, 33'h1_FFFF_FFFF);
        random_phase(150);
        drain();

        // inverted low and mid bands: only the high band can fit
        write_reg(REG_LOW_MIN, 33'd6000000000);
        write_reg(REG_LOW_MAX, 33'd1000);
        write_reg(REG_MID_MIN, 33'd6000000000);
        write_reg(REG_MID_MAX, 33'd0);
        write_reg(REG_HIGH_MIN, 33'd7000000000);
        write_reg(REG_HIGH_MAX, 33'd7714000000);
        random_phase(100);
        drain();

        // back to the usual plan with random bits on the reference
        write_reg(REG_REF_CLK, 33'(30'h3FFF_FFFF & $urandom));
        write_reg(REG_LOW_MIN, RST_LOW_MIN);
        write_reg(REG_LOW_MAX, RST_LOW_MAX);
        write_reg(REG_MID_MIN, RST_MID_MIN);
        write_reg(REG_MID_MAX, RST_MID_MAX);
        write_reg(REG_HIGH_MIN, RST_HIGH_MIN);
        write_reg(REG_HIGH_MAX, RST_HIGH_MAX);
        write_reg(REG_THRESHOLD, RST_THRESHOLD);
        random_phase(150);
        drain();
        write_reg(REG_REF_CLK, 33'd26000000);
        calm = 1'b1;
        random_phase(150);
        calm = 1'b0;
        random_phase(200);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
